// ----- rtl/mcop_pkg.sv -----
// Shared types, constants and helpers of the Monte Carlo option pricer.
`default_nettype none
package mcop_pkg;

	localparam int PRICE_BITS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ADDR_BITS       = 5;
	localparam int SUM_BITS        = 52;
	localparam int RECIP_SHIFT     = 37;

	localparam logic [31:0] RST_START    = 32'd6553600;
	localparam logic [31:0] RST_STRIKE   = 32'd6553600;
	localparam logic [31:0] RST_DRIFT    = 32'd127826;
	localparam logic [30:0] RST_VOL      = 31'd13527870;
	localparam logic [15:0] RST_STEPS    = 16'd252;
	localparam logic [19:0] RST_PATHS    = 20'd10000;
	localparam logic [31:0] RST_DISCOUNT = 32'd4085499268;
	localparam logic        RST_IS_PUT   = 1'b1;

	typedef enum logic [2:0] {
		REG_START_PRICE = 3'd0,
		REG_STRIKE      = 3'd1,
		REG_DRIFT       = 3'd2,
		REG_VOL         = 3'd3,
		REG_STEPS       = 3'd4,
		REG_PATHS       = 3'd5,
		REG_DISCOUNT    = 3'd6,
		REG_IS_PUT      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        start_price;
		logic [31:0]        strike;
		logic signed [31:0] drift;
		logic [30:0]        vol;
		logic [15:0]        steps;
		logic [19:0]        paths;
		logic [31:0]        discount;
		logic               is_put;
	} cfg_t;

	// One classified draw: exponent in Q.30 and where it falls in the run.
	typedef struct packed {
		logic signed [31:0] x30;
		logic               end_path;
		logic               end_run;
	} qent_t;

	// ceil(2^37 / k) for the Horner divisors; k of one bypasses the multiply.
	function automatic logic [RECIP_SHIFT-1:0] recip(input logic [3:0] k);
		logic [RECIP_SHIFT-1:0] r;
		unique case (k)
			4'd2:    r = 37'd68719476736;
			4'd3:    r = 37'd45812984491;
			4'd4:    r = 37'd34359738368;
			4'd5:    r = 37'd27487790695;
			4'd6:    r = 37'd22906492246;
			4'd7:    r = 37'd19634136211;
			4'd8:    r = 37'd17179869184;
			4'd9:    r = 37'd15270994831;
			4'd10:   r = 37'd13743895348;
			default: r = 37'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/mcop_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none
module mcop_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mcop_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output mcop_pkg::cfg_t                      cfg
);

	mcop_pkg::cfg_t   cfg_q;
	mcop_pkg::reg_idx_t idx;

	assign idx    = mcop_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_price <= mcop_pkg::RST_START;
			cfg_q.strike      <= mcop_pkg::RST_STRIKE;
			cfg_q.drift       <= mcop_pkg::RST_DRIFT;
			cfg_q.vol         <= mcop_pkg::RST_VOL;
			cfg_q.steps       <= mcop_pkg::RST_STEPS;
			cfg_q.paths       <= mcop_pkg::RST_PATHS;
			cfg_q.discount    <= mcop_pkg::RST_DISCOUNT;
			cfg_q.is_put      <= mcop_pkg::RST_IS_PUT;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				mcop_pkg::REG_START_PRICE: cfg_q.start_price <= pwdata;
				mcop_pkg::REG_STRIKE:      cfg_q.strike      <= pwdata;
				mcop_pkg::REG_DRIFT:       cfg_q.drift       <= pwdata;
				mcop_pkg::REG_VOL:         cfg_q.vol         <= pwdata[30:0];
				mcop_pkg::REG_STEPS:       cfg_q.steps       <= pwdata[15:0];
				mcop_pkg::REG_PATHS:       cfg_q.paths       <= pwdata[19:0];
				mcop_pkg::REG_DISCOUNT:    cfg_q.discount    <= pwdata;
				mcop_pkg::REG_IS_PUT:      cfg_q.is_put      <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mcop_pkg::REG_START_PRICE: prdata = cfg_q.start_price;
			mcop_pkg::REG_STRIKE:      prdata = cfg_q.strike;
			mcop_pkg::REG_DRIFT:       prdata = cfg_q.drift;
			mcop_pkg::REG_VOL:         prdata = {1'b0, cfg_q.vol};
			mcop_pkg::REG_STEPS:       prdata = {16'd0, cfg_q.steps};
			mcop_pkg::REG_PATHS:       prdata = {12'd0, cfg_q.paths};
			mcop_pkg::REG_DISCOUNT:    prdata = cfg_q.discount;
			mcop_pkg::REG_IS_PUT:      prdata = {31'd0, cfg_q.is_put};
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/mcop_front.sv -----
// Front end: takes draws, forms the clamped exponent and marks path/run ends.
`default_nettype none
module mcop_front #(
	parameter int SAMPLE_BITS = mcop_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mcop_pkg::cfg_t         cfg,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire logic [SAMPLE_BITS-1:0] normal_sample,
	input  wire logic                   q_full,
	output logic                        q_push,
	output mcop_pkg::qent_t             q_data
);

	localparam int PW = 32 + SAMPLE_BITS;
	localparam int XW = ((PW > 44) ? PW : 44) + 1;
	localparam logic signed [XW-1:0] XMAX = XW'(64'sd4398046511104);
	localparam logic signed [XW-1:0] XMIN = -XMAX;
	localparam logic signed [XW-1:0] XHALF = XW'(64'sd2048);

	logic                 valid_s1;
	logic signed [PW-1:0] prod_s1;
	logic                 end_path_s1;
	logic                 end_run_s1;
	logic [15:0]          step_q;
	logic [19:0]          path_q;

	logic                 accept;
	logic [16:0]          step_nx;
	logic [20:0]          path_nx;
	logic [16:0]          steps_eff;
	logic [20:0]          paths_eff;
	logic                 end_path;
	logic                 end_run;
	logic signed [XW-1:0] x_sum;
	logic signed [XW-1:0] x_cl;
	logic signed [XW-1:0] x_rnd;

	assign q_push       = valid_s1 && !q_full;
	assign sample_stall = valid_s1 && q_full;
	assign accept       = sample_valid && !sample_stall;

	assign steps_eff = (cfg.steps == 16'd0) ? 17'd1 : {1'b0, cfg.steps};
	assign paths_eff = (cfg.paths == 20'd0) ? 21'd1 : {1'b0, cfg.paths};
	assign step_nx   = {1'b0, step_q} + 17'd1;
	assign path_nx   = {1'b0, path_q} + 21'd1;
	assign end_path  = step_nx >= steps_eff;
	assign end_run   = end_path && (path_nx >= paths_eff);

	// Exponent: drift*2^12 + vol*z, clamp to +-1.0 in Q.42, round half up to Q.30.
	assign x_sum = (XW'(cfg.drift) <<< 12) + XW'(prod_s1);
	assign x_cl  = (x_sum > XMAX) ? XMAX : ((x_sum < XMIN) ? XMIN : x_sum);
	assign x_rnd = (x_cl + XHALF) >>> 12;

	assign q_data.x30      = x_rnd[31:0];
	assign q_data.end_path = end_path_s1;
	assign q_data.end_run  = end_run_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q   <= 16'd0;
			path_q   <= 20'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (end_path) begin
					step_q <= 16'd0;
					path_q <= end_run ? 20'd0 : path_nx[19:0];
				end else begin
					step_q <= step_nx[15:0];
				end
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1     <= $signed({1'b0, cfg.vol}) * $signed(normal_sample);
			end_path_s1 <= end_path;
			end_run_s1  <= end_run;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mcop_queue.sv -----
// Four-entry queue of classified draws between front and back.
`default_nettype none
module mcop_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mcop_pkg::qent_t wdata,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output mcop_pkg::qent_t      rdata
);

	mcop_pkg::qent_t mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;

	assign full  = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mcop_back.sv -----
// Back end: exp series, price update, payoff sum and final discounted mean.
`default_nettype none
module mcop_back #(
	parameter int PRICE_BITS = mcop_pkg::PRICE_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mcop_pkg::cfg_t  cfg,
	input  wire logic            q_empty,
	input  wire mcop_pkg::qent_t q_data,
	output logic                 q_pop,
	output logic                 price_valid,
	input  wire logic            price_stall,
	output logic [31:0]          option_price,
	output logic                 saturated
);

	localparam int PB = PRICE_BITS;
	localparam int SW = (PB > 32) ? PB : 32;
	localparam int SB = mcop_pkg::SUM_BITS;
	localparam int DW = SB + 32;
	localparam int RS = mcop_pkg::RECIP_SHIFT;
	localparam logic [SW-1:0] PMAX_W = SW'((65'd1 << PB) - 65'd1);
	localparam logic [PB-1:0] PMAX   = PB'(PMAX_W);
	localparam logic [PB-1:0] PRICE_RST = (SW'(mcop_pkg::RST_START) > PMAX_W) ?
		PMAX : PB'(mcop_pkg::RST_START);
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_SLO, ST_SHI, ST_SUM, ST_PAY,
		ST_FLO, ST_FHI, ST_FADD, ST_LDIV, ST_OUT
	} state_t;

	state_t                 state_q;
	logic signed [31:0]     x_q;
	logic                   end_path_q;
	logic                   end_run_q;
	logic [31:0]            p_q;
	logic [3:0]             k_q;
	logic signed [64:0]     prod_q;
	logic [PB-1:0]          price_q;
	logic [PB+15:0]         pplo_q;
	logic [PB+15:0]         pphi_q;
	logic [SB-1:0]          sum_q;
	logic                   sat_q;
	logic [SB+15:0]         flo_q;
	logic [SB+15:0]         fhi_q;
	logic [DW-1:0]          dd_q;
	logic [19:0]            rem_q;
	logic [6:0]             bit_q;
	logic                   out_valid_q;
	logic [31:0]            out_price_q;
	logic                   out_sat_q;

	logic                   neg;
	logic [64:0]            mag;
	logic [64:0]            mag_rnd;
	logic [32:0]            r33;
	logic [RS+32:0]         rq;
	logic [32:0]            q33;
	logic [33:0]            p_nx;
	logic [PB+32:0]         acc;
	logic [PB+2:0]          scaled;
	logic [SW-1:0]          price_w;
	logic [SW-1:0]          strike_w;
	logic [SW-1:0]          start_w;
	logic [SW-1:0]          pay;
	logic [SB:0]            sum_nx;
	logic [20:0]            n_eff;
	logic [20:0]            trial;
	logic [20:0]            shifted;
	logic [DW:0]            fin;
	logic [SB:0]            fin_hi;
	logic                   fin_over;
	logic                   out_free;

	assign q_pop        = (state_q == ST_IDLE) && !q_empty;
	assign price_valid  = out_valid_q;
	assign option_price = out_price_q;
	assign saturated    = out_sat_q;
	assign out_free     = !out_valid_q || !price_stall;

	// Horner term: round the Q.60 magnitude to Q.30, divide by k via reciprocal.
	assign neg     = prod_q[64];
	assign mag     = neg ? 65'(-prod_q) : 65'(prod_q);
	assign mag_rnd = mag + 65'(1 << 29);
	assign r33     = mag_rnd[62:30];
	assign rq      = r33 * mcop_pkg::recip(k_q);
	assign q33     = (k_q == 4'd1) ? r33 : rq[RS+32:RS];
	assign p_nx    = neg ? ({2'b0, ONE_Q30} - {1'b0, q33}) : ({2'b0, ONE_Q30} + {1'b0, q33});

	assign acc    = {17'd0, pplo_q} + {1'b0, pphi_q, 16'd0} + (PB+33)'(1 << 29);
	assign scaled = acc[PB+32:30];

	assign price_w  = SW'(price_q);
	assign strike_w = SW'(cfg.strike);
	assign start_w  = SW'(cfg.start_price);
	always_comb begin
		if (cfg.is_put) begin
			pay = (strike_w > price_w) ? (strike_w - price_w) : '0;
		end else begin
			pay = (price_w > strike_w) ? (price_w - strike_w) : '0;
		end
	end
	assign sum_nx = {1'b0, sum_q} + (SB+1)'(pay);

	assign n_eff   = (cfg.paths == 20'd0) ? 21'd1 : {1'b0, cfg.paths};
	assign shifted = {rem_q, dd_q[DW-1]};
	assign trial   = shifted - n_eff;

	assign fin      = {1'b0, dd_q} + (DW+1)'(64'd2147483648);
	assign fin_hi   = fin[DW:32];
	assign fin_over = |fin_hi[SB:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			price_q     <= PRICE_RST;
			sum_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!price_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						x_q        <= q_data.x30;
						end_path_q <= q_data.end_path;
						end_run_q  <= q_data.end_run;
						p_q        <= ONE_Q30;
						k_q        <= 4'd10;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= x_q * $signed({1'b0, p_q});
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					p_q <= p_nx[31:0];
					if (k_q == 4'd1) begin
						state_q <= ST_SLO;
					end else begin
						k_q     <= k_q - 4'd1;
						state_q <= ST_MUL;
					end
				end
				ST_SLO: begin
					pplo_q  <= price_q * p_q[15:0];
					state_q <= ST_SHI;
				end
				ST_SHI: begin
					pphi_q  <= price_q * p_q[31:16];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// Stick at the top price and flag it.
					if (|scaled[PB+2:PB]) begin
						price_q <= PMAX;
						sat_q   <= 1'b1;
					end else begin
						price_q <= scaled[PB-1:0];
					end
					state_q <= end_path_q ? ST_PAY : ST_IDLE;
				end
				ST_PAY: begin
					if (sum_nx[SB]) begin
						sum_q <= '1;
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_nx[SB-1:0];
					end
					price_q <= (start_w > PMAX_W) ? PMAX : PB'(cfg.start_price);
					state_q <= end_run_q ? ST_FLO : ST_IDLE;
				end
				ST_FLO: begin
					flo_q   <= sum_q * cfg.discount[15:0];
					state_q <= ST_FHI;
				end
				ST_FHI: begin
					fhi_q   <= sum_q * cfg.discount[31:16];
					state_q <= ST_FADD;
				end
				ST_FADD: begin
					dd_q    <= DW'(flo_q) + {fhi_q, 16'd0};
					rem_q   <= 20'd0;
					bit_q   <= 7'd0;
					state_q <= ST_LDIV;
				end
				ST_LDIV: begin
					// One quotient bit per cycle, restoring.
					if (!trial[20]) begin
						rem_q <= trial[19:0];
						dd_q  <= {dd_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= shifted[19:0];
						dd_q  <= {dd_q[DW-2:0], 1'b0};
					end
					bit_q <= bit_q + 7'd1;
					if (bit_q == 7'(DW - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_price_q <= fin_over ? 32'hFFFF_FFFF : fin_hi[31:0];
						out_sat_q   <= sat_q || fin_over;
						sum_q       <= '0;
						sat_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/monte_carlo_option_pricer_core.sv -----
// Top level of the Monte Carlo European option pricer.
// Usage:
//   Sample channel: one standard normal draw (Q4.12) per word on normal_sample,
//   taken when sample_valid is high and sample_stall is low.
//   Price channel: one word per run, option_price (Q16.16) and saturated, after
//   the last draw of the last path; held while price_stall is high.
//   Configuration: APB-style writes at byte address 4*index; pready is always high.
// Back end, per draw: one pop, ten multiply/divide pairs of the exp series on
//   the shared Horner multiplier and reciprocal divide, then the price multiply
//   in low-half, high-half and sum steps; the next draw is popped only then.
//   A path end adds a payoff step; a run end adds the discount product (low
//   half, high half, add), an 84-bit bit-serial divide by the path count
//   and a load of the output register.
// A four-word queue parts front and back, so draws keep flowing in while the
//   back end works, and the back end keeps working while a result waits.
// Reset: registers return to their defaults, the path price loads the start
//   price, counters and the payoff sum clear; nothing is output.
// When the receiver stalls, the result word holds; the back end waits only
//   if a second result is ready before the first is taken.
`default_nettype none
module monte_carlo_option_pricer_core #(
	parameter int PRICE_BITS  = mcop_pkg::PRICE_BITS_DEF,
	parameter int SAMPLE_BITS = mcop_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mcop_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  wire logic                           sample_valid,
	output logic                                sample_stall,
	input  wire logic [SAMPLE_BITS-1:0]         normal_sample,
	output logic                                price_valid,
	input  wire logic                           price_stall,
	output logic [31:0]                         option_price,
	output logic                                saturated
);

	mcop_pkg::cfg_t  cfg;
	mcop_pkg::qent_t push_data;
	mcop_pkg::qent_t pop_data;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	// Register file.
	mcop_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front: accept draws, form exponent, tag path and run ends.
	mcop_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.normal_sample (normal_sample),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	// Hold classified draws until the back end is free.
	mcop_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_data),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (pop_data)
	);

	// Back: advance the path price, sum payoffs, emit the discounted mean.
	mcop_back #(
		.PRICE_BITS (PRICE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.price_valid  (price_valid),
		.price_stall  (price_stall),
		.option_price (option_price),
		.saturated    (saturated)
	);

endmodule
`default_nettype wire
